>>> src/aot_pkg.sv
// ----------------------------------------------------------------------------
// aot_pkg
// Shared types, register indexes and constants of the arc odometry tracker.
// ----------------------------------------------------------------------------
package aot_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int NUM_W       = 54;  // travel * 65536*256/(2 pi) numerator
	localparam int DEN_W       = 24;  // turn * 256 denominator
	localparam int DIST_W      = 46;  // arc radius / chord width
	localparam int CFG_IDX_W   = 3;

	localparam logic [23:0]        WHEEL_SCALE_RST = 24'd1573;
	localparam logic signed [24:0] INV_TWO_PI_Q8   = 25'sd2670177;
	localparam logic [14:0]        SIN_A           = 15'd25736;
	localparam logic [13:0]        SIN_B           = 14'd10512;
	localparam logic [10:0]        SIN_C           = 11'd1160;
	localparam logic [14:0]        QUARTER_TURN    = 15'd16384;
	localparam logic [15:0]        COS_SHIFT       = 16'h4000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEEL_SCALE    = 3'd0,
		REG_OFFSET_FORWARD = 3'd1,
		REG_OFFSET_SIDE    = 3'd2,
		REG_ORIGIN_X       = 3'd3,
		REG_ORIGIN_Y       = 3'd4,
		REG_HEADING_OFFSET = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] imu_heading;
		logic               imu_calibrating;
		logic signed [31:0] forward_count;
		logic signed [31:0] side_count;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [15:0] turn_rate;
		logic               updated;
	} out_t;

	typedef struct packed {
		logic [23:0]        wheel_scale;
		logic signed [23:0] offset_forward;
		logic signed [23:0] offset_side;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [15:0] heading_offset;
	} cfg_t;

	typedef struct packed {
		logic               upd;
		logic [15:0]        cur;
		logic [15:0]        rate;
		logic signed [31:0] df;
		logic signed [31:0] ds;
	} ent_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_OUT,
		ST_TF,
		ST_TS,
		ST_KF,
		ST_KS,
		ST_DIV,
		ST_SN0,
		ST_SN1,
		ST_SN2,
		ST_SN3,
		ST_SN4,
		ST_WAIT,
		ST_ARC,
		ST_W_LO,
		ST_W_HI,
		ST_W_ACC,
		ST_FIN
	} back_state_t;

	typedef enum logic [1:0] {
		SEL_SIN_HEAD,
		SEL_COS_HEAD,
		SEL_SIN_RATE
	} sine_sel_t;

	typedef enum logic [2:0] {
		JOB_ARC_F,
		JOB_ARC_S,
		JOB_XF,
		JOB_XS,
		JOB_YF,
		JOB_YS
	} job_t;

endpackage

>>> src/aot_queue.sv
// ----------------------------------------------------------------------------
// aot_queue
// Small FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module aot_queue import aot_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ent_t wdata,
	input  logic pop,
	output ent_t rdata,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	ent_t             mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(Depth));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/aot_front.sv
// ----------------------------------------------------------------------------
// aot_front
// Accepts ticks, negates the heading, forms turn and encoder deltas.
// ----------------------------------------------------------------------------
module aot_front import aot_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	input  logic q_full,
	output logic q_push,
	output ent_t q_wdata
);

	logic [31:0] prev_forward_q;
	logic [31:0] prev_side_q;
	logic [15:0] cur_angle_q;
	logic [15:0] rate_q;
	logic [15:0] neg_heading;

	assign in_ready    = !q_full;
	assign q_push      = in_valid && in_ready;
	assign neg_heading = 16'(~in_data.imu_heading) + 16'd1;

	always_comb begin
		q_wdata.upd = !in_data.imu_calibrating;
		if (in_data.imu_calibrating) begin
			q_wdata.cur  = cur_angle_q;
			q_wdata.rate = rate_q;
			q_wdata.df   = '0;
			q_wdata.ds   = '0;
		end else begin
			q_wdata.cur  = neg_heading;
			q_wdata.rate = neg_heading - cur_angle_q;
			q_wdata.df   = in_data.forward_count - prev_forward_q;
			q_wdata.ds   = in_data.side_count - prev_side_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_forward_q <= '0;
			prev_side_q    <= '0;
			cur_angle_q    <= '0;
			rate_q         <= '0;
		end else if (q_push && !in_data.imu_calibrating) begin
			prev_forward_q <= in_data.forward_count;
			prev_side_q    <= in_data.side_count;
			cur_angle_q    <= neg_heading;
			rate_q         <= q_wdata.rate;
		end
	end

endmodule

>>> src/aot_div.sv
// ----------------------------------------------------------------------------
// aot_div
// Signed restoring divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module aot_div import aot_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic                    busy,
	output logic signed [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dmag_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dmag_q};
	assign ge    = (trial >= {1'b0, dmag_q});
	assign busy  = busy_q;
	assign quo   = neg_q ? -signed'(acc_q) : signed'(acc_q);

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= num[NUM_W-1] ? NUM_W'(-num) : num;
			dmag_q <= den[DEN_W-1] ? DEN_W'(-den) : den;
			neg_q  <= num[NUM_W-1] ^ den[DEN_W-1];
			rem_q  <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/aot_back.sv
// ----------------------------------------------------------------------------
// aot_back
// Sequencer with one shared multiplier: travel, sines, arc chord, rotation.
// ----------------------------------------------------------------------------
module aot_back import aot_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  ent_t q_rdata,
	input  logic q_empty,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	back_state_t state_q, state_d;
	sine_sel_t   sel_q;
	job_t        job_q;
	ent_t        ent_q;

	logic signed [31:0]       tf_q, ts_q;
	logic signed [NUM_W-1:0]  numf_q;
	logic [14:0]              t_q, t2_q;
	logic [1:0]               quad_q;
	logic signed [15:0]       sin_h_q, cos_h_q, sin_r_q;
	logic signed [DIST_W-1:0] af_q, as_q, dist_f_q, dist_s_q;
	logic signed [63:0]       lo_q, px_q, py_q;
	logic [31:0]              disp_x_q, disp_y_q, step_x_q, step_y_q;
	out_t                     out_q;
	logic                     out_valid_q;
	logic signed [57:0]       prod_q;

	logic signed [32:0]       mul_a;
	logic signed [24:0]       mul_b;
	logic                     rate_nz;
	logic [15:0]              head, ang;
	logic [14:0]              t_in, v;
	logic [10:0]              r1;
	logic [13:0]              r2;
	logic signed [DIST_W-1:0] wx;
	logic signed [15:0]       wy;
	logic signed [63:0]       full;
	logic signed [31:0]       vx, vy;
	logic                     div_start;
	logic                     busy_f, busy_s;
	logic signed [NUM_W-1:0]  quo_f, quo_s;
	logic signed [DEN_W-1:0]  den;

	function automatic logic signed [31:0] sat32(input logic signed [57:0] x);
		if (x > 58'sh7FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end else if (x < -58'sh80000000) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	assign rate_nz   = (ent_q.rate != '0);
	assign head      = ent_q.cur + cfg.heading_offset;
	assign den       = {ent_q.rate, 8'd0};
	assign r1        = prod_q[24:14];
	assign r2        = prod_q[27:14];
	assign v         = prod_q[28:14];
	assign full      = (64'(prod_q) <<< 23) + lo_q;
	assign vx        = px_q[45:14];
	assign vy        = py_q[45:14];
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		case (sel_q)
			SEL_SIN_HEAD: ang = head;
			SEL_COS_HEAD: ang = head + COS_SHIFT;
			default:      ang = ent_q.rate;
		endcase
		t_in = ang[14] ? QUARTER_TURN - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
	end

	always_comb begin
		case (job_q)
			JOB_ARC_F: begin wx = af_q;     wy = sin_r_q; end
			JOB_ARC_S: begin wx = as_q;     wy = sin_r_q; end
			JOB_XF:    begin wx = dist_f_q; wy = cos_h_q; end
			JOB_XS:    begin wx = dist_s_q; wy = sin_h_q; end
			JOB_YF:    begin wx = dist_f_q; wy = sin_h_q; end
			default:   begin wx = dist_s_q; wy = cos_h_q; end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty && !out_valid_q) begin
					state_d = q_rdata.upd ? ST_TF : ST_OUT;
				end
			end
			ST_OUT: state_d = ST_IDLE;
			ST_TF:  state_d = ST_TS;
			ST_TS:  state_d = ST_KF;
			ST_KF:  state_d = ST_KS;
			ST_KS:  state_d = ST_DIV;
			ST_DIV: state_d = ST_SN0;
			ST_SN0: state_d = ST_SN1;
			ST_SN1: state_d = ST_SN2;
			ST_SN2: state_d = ST_SN3;
			ST_SN3: state_d = ST_SN4;
			ST_SN4: begin
				case (sel_q)
					SEL_SIN_HEAD: state_d = ST_SN0;
					SEL_COS_HEAD: state_d = rate_nz ? ST_SN0 : ST_W_LO;
					default:      state_d = ST_WAIT;
				endcase
			end
			ST_WAIT: begin
				if (!busy_f && !busy_s) begin
					state_d = ST_ARC;
				end
			end
			ST_ARC:   state_d = ST_W_LO;
			ST_W_LO:  state_d = ST_W_HI;
			ST_W_HI:  state_d = ST_W_ACC;
			ST_W_ACC: state_d = (job_q == JOB_YS) ? ST_FIN : ST_W_LO;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs and multiplier operands
	always_comb begin
		q_pop     = (state_q == ST_IDLE) && !q_empty && !out_valid_q;
		div_start = (state_q == ST_DIV) && rate_nz;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_TF: begin
				mul_a = {ent_q.df[31], ent_q.df};
				mul_b = {1'b0, cfg.wheel_scale};
			end
			ST_TS: begin
				mul_a = {ent_q.ds[31], ent_q.ds};
				mul_b = {1'b0, cfg.wheel_scale};
			end
			ST_KF: begin
				mul_a = {tf_q[31], tf_q};
				mul_b = INV_TWO_PI_Q8;
			end
			ST_KS: begin
				mul_a = {ts_q[31], ts_q};
				mul_b = INV_TWO_PI_Q8;
			end
			ST_SN0: begin
				mul_a = {18'd0, t_in};
				mul_b = {10'd0, t_in};
			end
			ST_SN1: begin
				mul_a = {18'd0, v};
				mul_b = {14'd0, SIN_C};
			end
			ST_SN2: begin
				mul_a = {19'd0, SIN_B - {3'd0, r1}};
				mul_b = {10'd0, t2_q};
			end
			ST_SN3: begin
				mul_a = {18'd0, SIN_A - {1'b0, r2}};
				mul_b = {10'd0, t_q};
			end
			ST_W_LO: begin
				mul_a = {10'd0, wx[22:0]};
				mul_b = {{9{wy[15]}}, wy};
			end
			ST_W_HI: begin
				mul_a = {{10{wx[DIST_W-1]}}, wx[DIST_W-1:23]};
				mul_b = {{9{wy[15]}}, wy};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: if (q_pop) ent_q <= q_rdata;
			ST_TS:   tf_q <= sat32(prod_q);
			ST_KF:   ts_q <= sat32(prod_q);
			ST_KS:   numf_q <= prod_q[NUM_W-1:0];
			ST_SN0: begin
				t_q    <= t_in;
				quad_q <= ang[15:14];
			end
			ST_SN1:  t2_q <= v;
			ST_SN4: begin
				case (sel_q)
					SEL_SIN_HEAD: sin_h_q <= quad_q[1] ? -signed'({1'b0, v}) : {1'b0, v};
					SEL_COS_HEAD: cos_h_q <= quad_q[1] ? -signed'({1'b0, v}) : {1'b0, v};
					default:      sin_r_q <= quad_q[1] ? -signed'({1'b0, v}) : {1'b0, v};
				endcase
				if (sel_q == SEL_COS_HEAD && !rate_nz) begin
					dist_f_q <= DIST_W'(tf_q);
					dist_s_q <= DIST_W'(ts_q);
				end
			end
			ST_ARC: begin
				af_q <= quo_f[DIST_W-1:0] + DIST_W'(cfg.offset_forward);
				as_q <= quo_s[DIST_W-1:0] - DIST_W'(cfg.offset_side);
			end
			ST_W_HI: lo_q <= 64'(prod_q);
			ST_W_ACC: begin
				case (job_q)
					JOB_ARC_F: dist_f_q <= full[DIST_W+13:14];
					JOB_ARC_S: dist_s_q <= full[DIST_W+13:14];
					JOB_XF:    px_q <= full;
					JOB_XS:    px_q <= px_q + full;
					JOB_YF:    py_q <= full;
					default:   py_q <= py_q - full;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= SEL_SIN_HEAD;
			job_q       <= JOB_ARC_F;
			disp_x_q    <= '0;
			disp_y_q    <= '0;
			step_x_q    <= '0;
			step_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_DIV: sel_q <= SEL_SIN_HEAD;
				ST_SN4: begin
					if (sel_q == SEL_SIN_HEAD) begin
						sel_q <= SEL_COS_HEAD;
					end else if (sel_q == SEL_COS_HEAD) begin
						sel_q <= SEL_SIN_RATE;
						job_q <= JOB_XF;
					end
				end
				ST_ARC:   job_q <= JOB_ARC_F;
				ST_W_ACC: job_q <= job_t'(job_q + 3'd1);
				ST_OUT: begin
					out_valid_q <= 1'b1;
				end
				ST_FIN: begin
					step_x_q    <= vx;
					step_y_q    <= vy;
					disp_x_q    <= disp_x_q + vx;
					disp_y_q    <= disp_y_q + vy;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			out_q.pos_x     <= disp_x_q + cfg.origin_x;
			out_q.pos_y     <= disp_y_q + cfg.origin_y;
			out_q.heading   <= head;
			out_q.vel_x     <= step_x_q;
			out_q.vel_y     <= step_y_q;
			out_q.turn_rate <= ent_q.rate;
			out_q.updated   <= 1'b0;
		end else if (state_q == ST_FIN) begin
			out_q.pos_x     <= disp_x_q + vx + cfg.origin_x;
			out_q.pos_y     <= disp_y_q + vy + cfg.origin_y;
			out_q.heading   <= head;
			out_q.vel_x     <= vx;
			out_q.vel_y     <= vy;
			out_q.turn_rate <= ent_q.rate;
			out_q.updated   <= 1'b1;
		end
	end

	aot_div u_div_f (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (numf_q),
		.den    (den),
		.busy   (busy_f),
		.quo    (quo_f)
	);

	aot_div u_div_s (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q[NUM_W-1:0]),
		.den    (den),
		.busy   (busy_s),
		.quo    (quo_s)
	);

endmodule

>>> src/arc_odometry_tracker.sv
// ----------------------------------------------------------------------------
// arc_odometry_tracker
// Two tracking wheels plus IMU heading, arc-chord odometry in Q16.16.
// ----------------------------------------------------------------------------
// Ticks are taken into a two-item queue whenever it has room and are worked
// off one at a time by a sequencer around a single 33x25 multiplier. A tick
// during IMU calibration leaves the queue and gives a held result through
// the ST_OUT state. With a nonzero turn the two radius dividers run while
// the sines are evaluated; with zero turn they and the turn sine are skipped.
// The next tick is started only once the previous result has been taken.
// Configuration writes are taken every cycle.
module arc_odometry_tracker import aot_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t cfg_q;
	ent_t q_wdata, q_rdata;
	logic q_push, q_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_scale    <= WHEEL_SCALE_RST;
			cfg_q.offset_forward <= '0;
			cfg_q.offset_side    <= '0;
			cfg_q.origin_x       <= '0;
			cfg_q.origin_y       <= '0;
			cfg_q.heading_offset <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WHEEL_SCALE:    cfg_q.wheel_scale    <= cfg_data[23:0];
				REG_OFFSET_FORWARD: cfg_q.offset_forward <= cfg_data[23:0];
				REG_OFFSET_SIDE:    cfg_q.offset_side    <= cfg_data[23:0];
				REG_ORIGIN_X:       cfg_q.origin_x       <= cfg_data;
				REG_ORIGIN_Y:       cfg_q.origin_y       <= cfg_data;
				REG_HEADING_OFFSET: cfg_q.heading_offset <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	aot_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	aot_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	aot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_valid)
		else $error("item started while result pending");

	a_calib_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && !q_rdata.upd |-> ##2 (out_valid && !out_data.updated))
		else $error("calibrating item gave no held result");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the arc odometry tracker: a directed table of ticks,
// then random wheel-and-heading walks over several register settings and
// handshake idling modes; scored by an in-bench odometry model or typed rows.
// ----------------------------------------------------------------------------
module tb;
	import aot_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 240;

	typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

	typedef struct {
		in_t  item;
		bit   known;
		out_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	arc_odometry_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// odometry model state
	cfg_t        odo_cfg;
	logic [31:0] odo_prev_fwd, odo_prev_side, odo_disp_x, odo_disp_y, odo_step_x, odo_step_y;
	logic [15:0] odo_prev_angle, odo_cur_angle, odo_rate;

	out_t       pose_q[$];
	int         fail_count;
	int         quiet_cycles;
	idle_mode_t idle_mode;

	dir_row_t dir_rows[12] = '{
		'{'{16'sd0, 1'b0, 32'sd0, 32'sd0}, 1'b1,
			'{32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b1}},
		'{'{16'sd0, 1'b1, 32'sd0, 32'sd0}, 1'b1,
			'{32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b0}},
		'{'{-16'sd32768, 1'b0, 32'sd0, 32'sd0}, 1'b1,
			'{32'sd0, 32'sd0, -16'sd32768, 32'sd0, 32'sd0, -16'sd32768, 1'b1}},
		'{'{16'sd32767, 1'b0, 32'sd1000, 32'sd0}, 1'b0, '0},
		'{'{16'sd32767, 1'b0, 32'sd2000, -32'sd500}, 1'b0, '0},
		'{'{16'sd32767, 1'b0, 32'sd2147483647, -32'sd2147483648}, 1'b0, '0},
		'{'{16'sd32767, 1'b0, -32'sd2147483648, 32'sd2147483647}, 1'b0, '0},
		'{'{-16'sd1000, 1'b0, 32'sd5000, 32'sd300}, 1'b0, '0},
		'{'{-16'sd1000, 1'b1, 32'sd9000, -32'sd9000}, 1'b0, '0},
		'{'{-16'sd1200, 1'b0, 32'sd9000, -32'sd9000}, 1'b0, '0},
		'{'{16'sd16384, 1'b0, 32'sd12000, 32'sd100}, 1'b0, '0},
		'{'{-16'sd16384, 1'b0, 32'sd0, 32'sd0}, 1'b0, '0}
	};

	function automatic int sine_q14(logic [15:0] ang);
		int unsigned t, t2, r;
		t = ang[13:0];
		if (ang[14])
			t = 16384 - t;
		t2 = (t * t) >> 14;
		r = (int'(SIN_C) * t2) >> 14;
		r = ((int'(SIN_B) - r) * t2) >> 14;
		r = ((int'(SIN_A) - r) * t) >> 14;
		return ang[15] ? -int'(r) : int'(r);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic out_t odo_advance(in_t it);
		logic signed [31:0] d32;
		logic signed [15:0] r16;
		logic [15:0]        cur, hd;
		longint             df, ds, tf, ts, f, s, den, sn, sh, ch, vx, vy;
		out_t               o;
		if (!it.imu_calibrating) begin
			cur = 16'h0 - it.imu_heading;
			odo_rate = cur - odo_prev_angle;
			odo_prev_angle = cur;
			odo_cur_angle = cur;
			d32 = it.forward_count - odo_prev_fwd;
			df = d32;
			d32 = it.side_count - odo_prev_side;
			ds = d32;
			odo_prev_fwd = it.forward_count;
			odo_prev_side = it.side_count;
			tf = clamp32(df * longint'(odo_cfg.wheel_scale));
			ts = clamp32(ds * longint'(odo_cfg.wheel_scale));
			r16 = odo_rate;
			if (r16 != 0) begin
				sn = sine_q14(odo_rate);
				den = longint'(r16) * 256;
				f = (tf * longint'(INV_TWO_PI_Q8)) / den;
				s = (ts * longint'(INV_TWO_PI_Q8)) / den;
				f = ((f + longint'(odo_cfg.offset_forward)) * sn) >>> 14;
				s = ((s - longint'(odo_cfg.offset_side)) * sn) >>> 14;
			end else begin
				f = tf;
				s = ts;
			end
			hd = odo_cur_angle + odo_cfg.heading_offset;
			sh = sine_q14(hd);
			ch = sine_q14(hd + COS_SHIFT);
			vx = (f * ch + s * sh) >>> 14;
			vy = (f * sh - s * ch) >>> 14;
			odo_step_x = vx[31:0];
			odo_step_y = vy[31:0];
			odo_disp_x = odo_disp_x + odo_step_x;
			odo_disp_y = odo_disp_y + odo_step_y;
		end
		o.pos_x = odo_disp_x + odo_cfg.origin_x;
		o.pos_y = odo_disp_y + odo_cfg.origin_y;
		o.heading = odo_cur_angle + odo_cfg.heading_offset;
		o.vel_x = odo_step_x;
		o.vel_y = odo_step_y;
		o.turn_rate = odo_rate;
		o.updated = !it.imu_calibrating;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic bit roll_idle(bit sender);
		case (idle_mode)
			IDLE_SEND: return sender && $urandom_range(99) < 47;
			IDLE_RECV: return !sender && $urandom_range(99) < 47;
			IDLE_BOTH: return $urandom_range(99) < 16;
			default:   return 1'b0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side
	initial begin
		out_t want;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					report_mismatch("unexpected item", 32'(out_data.updated), 32'h0);
				end else begin
					want = pose_q.pop_front();
					if (out_data.pos_x !== want.pos_x)
						report_mismatch("pos_x", out_data.pos_x, want.pos_x);
					if (out_data.pos_y !== want.pos_y)
						report_mismatch("pos_y", out_data.pos_y, want.pos_y);
					if (out_data.heading !== want.heading)
						report_mismatch("heading", 32'(out_data.heading), 32'(want.heading));
					if (out_data.vel_x !== want.vel_x)
						report_mismatch("vel_x", out_data.vel_x, want.vel_x);
					if (out_data.vel_y !== want.vel_y)
						report_mismatch("vel_y", out_data.vel_y, want.vel_y);
					if (out_data.turn_rate !== want.turn_rate)
						report_mismatch("turn_rate", 32'(out_data.turn_rate),
							32'(want.turn_rate));
					if (out_data.updated !== want.updated)
						report_mismatch("updated", 32'(out_data.updated), 32'(want.updated));
				end
			end
			out_ready <= arst_n && !roll_idle(1'b0);
		end
	end

	// watchdog
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send_tick(in_t it, bit known, out_t typed);
		out_t pred;
		if (roll_idle(1'b1)) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (roll_idle(1'b1));
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		pred = odo_advance(it);
		pose_q.push_back(known ? typed : pred);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WHEEL_SCALE:    odo_cfg.wheel_scale = val[23:0];
			REG_OFFSET_FORWARD: odo_cfg.offset_forward = val[23:0];
			REG_OFFSET_SIDE:    odo_cfg.offset_side = val[23:0];
			REG_ORIGIN_X:       odo_cfg.origin_x = val;
			REG_ORIGIN_Y:       odo_cfg.origin_y = val;
			REG_HEADING_OFFSET: odo_cfg.heading_offset = val[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pose_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_setting(int k);
		case (k)
			1: begin
				write_reg(REG_WHEEL_SCALE, 32'hFFFFFF);
				write_reg(REG_OFFSET_FORWARD, 32'h7FFFFF);
				write_reg(REG_OFFSET_SIDE, 32'h7FFFFF);
				write_reg(REG_ORIGIN_X, 32'h7FFFFFFF);
				write_reg(REG_ORIGIN_Y, 32'h7FFFFFFF);
				write_reg(REG_HEADING_OFFSET, 32'h7FFF);
			end
			2: begin
				write_reg(REG_WHEEL_SCALE, 32'h0);
				write_reg(REG_OFFSET_FORWARD, 32'h800000);
				write_reg(REG_OFFSET_SIDE, 32'h800000);
				write_reg(REG_ORIGIN_X, 32'h80000000);
				write_reg(REG_ORIGIN_Y, 32'h80000000);
				write_reg(REG_HEADING_OFFSET, 32'h8000);
			end
			default: begin
				write_reg(REG_WHEEL_SCALE, $urandom_range(4000));
				write_reg(REG_OFFSET_FORWARD, $urandom);
				write_reg(REG_OFFSET_SIDE, $urandom);
				write_reg(REG_ORIGIN_X, $urandom);
				write_reg(REG_ORIGIN_Y, $urandom);
				write_reg(REG_HEADING_OFFSET, $urandom);
				write_reg(REG_SPARE_LO, $urandom);
				write_reg(REG_SPARE_HI, $urandom);
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	initial begin
		in_t         it;
		logic [15:0] walk_head;
		logic [31:0] walk_fwd, walk_side;
		int          roll;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		idle_mode = IDLE_NONE;
		odo_cfg = '0;
		odo_cfg.wheel_scale = WHEEL_SCALE_RST;
		{odo_prev_fwd, odo_prev_side, odo_disp_x, odo_disp_y, odo_step_x, odo_step_y} = '0;
		{odo_prev_angle, odo_cur_angle, odo_rate} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_tick(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
		drain();

		walk_head = '0;
		walk_fwd = '0;
		walk_side = '0;
		for (int ph = 0; ph < 6; ph++) begin
			idle_mode = idle_mode_t'(ph % 4);
			if (ph > 0)
				write_setting(ph);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < 6) begin
					it.imu_heading = 16'($urandom);
					it.imu_calibrating = 1'($urandom);
					it.forward_count = $urandom;
					it.side_count = $urandom;
				end else begin
					if ($urandom_range(3) != 0)
						walk_head = walk_head + 16'($urandom_range(2000)) - 16'd1000;
					if ($urandom_range(19) == 0)
						walk_fwd = walk_fwd + $urandom;
					else
						walk_fwd = walk_fwd + 32'($urandom_range(10000)) - 32'd5000;
					walk_side = walk_side + 32'($urandom_range(4000)) - 32'd2000;
					it.imu_heading = walk_head;
					it.imu_calibrating = roll < 14;
					it.forward_count = walk_fwd;
					it.side_count = walk_side;
				end
				send_tick(it, 1'b0, '0);
			end
			drain();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
